// ===== sv/nwl_pkg.sv =====
// ----------------------------------------------------------------------------
// nwl_pkg
// Shared types, codes and helpers for the tree text token lexer.
// ----------------------------------------------------------------------------
package nwl_pkg;

  localparam int TOKEN_LIMIT_MAX = 1022;
  localparam int LEN_W           = 10;
  localparam int QDEPTH          = 4;
  localparam int QPTR_W          = $clog2(QDEPTH);
  localparam int QLVL_W          = QPTR_W + 1;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(1022);

  localparam logic [2:0] KIND_LPAREN = 3'd0;
  localparam logic [2:0] KIND_RPAREN = 3'd1;
  localparam logic [2:0] KIND_COLON  = 3'd2;
  localparam logic [2:0] KIND_SEMI   = 3'd3;
  localparam logic [2:0] KIND_COMMA  = 3'd4;
  localparam logic [2:0] KIND_STRING = 3'd5;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_LONG    = 2'd1;
  localparam logic [1:0] ERR_UNTERM  = 2'd2;

  localparam logic [7:0] CH_SQUOTE   = 8'h27;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;

  typedef enum logic [2:0] {
    MODE_BETWEEN,
    MODE_UNQ,
    MODE_SQ,
    MODE_DQ,
    MODE_COMMENT,
    MODE_DRAIN_UNQ,
    MODE_DRAIN_SQ,
    MODE_DRAIN_DQ
  } mode_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [2:0] token_kind;
    logic [7:0] token_char;
    logic       char_valid;
    logic       token_end;
    logic [1:0] error_code;
  } out_item_t;

  // Results of one request: up to two items.
  typedef struct packed {
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;
  } nwl_step_t;

  typedef struct packed {
    logic [QLVL_W-1:0] level;
    logic              room2;
  } nwl_q_stat_t;

  function automatic logic [2:0] delim_kind(input logic [7:0] c);
    logic [2:0] k;
    case (c)
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_COLON:  k = KIND_COLON;
      CH_SEMI:   k = KIND_SEMI;
      CH_COMMA:  k = KIND_COMMA;
      default:   k = KIND_STRING;
    endcase
    return k;
  endfunction

  function automatic logic is_white(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic out_item_t mk_item(input logic [2:0] kind, input logic [7:0] ch,
                                        input logic vld, input logic last,
                                        input logic [1:0] err);
    out_item_t it;
    it.token_kind = kind;
    it.token_char = ch;
    it.char_valid = vld;
    it.token_end  = last;
    it.error_code = err;
    return it;
  endfunction

endpackage

// ===== sv/newick_token_lexer.sv =====
// ----------------------------------------------------------------------------
// newick_token_lexer
// Streaming tokenizer for tree text: one byte per request, token results out.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction
//  in      | in_valid, in_ready, in_data    | text bytes / end-of-input in
//  out     | out_valid, out_ready, out_data | token results out
//  cfg     | cfg_wr_en, cfg_wr_data         | max token length write
//
//  One request per cycle while in_ready is high; its results land in the
//  result queue the next cycle. Results leave one per cycle while
//  out_ready is high; a delimiter ending an unquoted string gives two results.
//  in_ready depends only on queue level (room for two). Sync reset; no clearing.
// ----------------------------------------------------------------------------
module newick_token_lexer import nwl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  logic [LEN_W-1:0] max_len_r;
  logic [LEN_W-1:0] limit;
  logic             fire;
  nwl_step_t        step;
  nwl_q_stat_t      q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  assign limit    = (32'(max_len_r) > TOKEN_LIMIT_MAX) ? LEN_W'(TOKEN_LIMIT_MAX) : max_len_r;
  assign in_ready = q_stat.room2;
  assign fire     = in_valid && in_ready;

  nwl_lex_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_data),
    .limit (limit),
    .step  (step)
  );

  nwl_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (fire ? step.n : 2'd0),
    .push_r0    (step.r0),
    .push_r1    (step.r1),
    .pop        (out_ready),
    .head_valid (out_valid),
    .head       (out_data),
    .stat       (q_stat)
  );

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.level <= QLVL_W'(QDEPTH))
    else $error("result queue overflow");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.error_code != ERR_NONE) |->
      out_data.token_end && !out_data.char_valid && (out_data.token_char == 8'h00))
    else $error("error result malformed");

  a_nochar_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.char_valid |-> (out_data.token_char == 8'h00))
    else $error("token_char set without char_valid");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (step.n != 2'd0) |=> q_stat.level != '0)
    else $error("queue empty after request");
`endif

endmodule

// ===== sv/nwl_lex_core.sv =====
// ----------------------------------------------------------------------------
// nwl_lex_core
// Lexer state and combinational step logic: one request in, up to two results.
// ----------------------------------------------------------------------------
module nwl_lex_core import nwl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  in_item_t         item,
  input  logic [LEN_W-1:0] limit,
  output nwl_step_t        step
);

  mode_t            mode_r, mode_nxt;
  logic [LEN_W-1:0] chars_r, chars_nxt;

  logic [7:0] c;
  logic [2:0] dk;
  logic       dlm, ws, over_cur, over_new;
  out_item_t  close_it, unterm_it, dlm_it, sb_cur, sb_new;
  mode_t      drain_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_BETWEEN;
      chars_r <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      chars_r <= chars_nxt;
    end
  end

  always_comb begin
    c         = item.char_byte;
    dk        = delim_kind(c);
    dlm       = (dk != KIND_STRING);
    ws        = is_white(c);
    over_cur  = (chars_r >= limit);
    over_new  = (limit == '0);
    close_it  = mk_item(KIND_STRING, 8'h00, 1'b0, 1'b1, ERR_NONE);
    unterm_it = mk_item(KIND_STRING, 8'h00, 1'b0, 1'b1, ERR_UNTERM);
    dlm_it    = mk_item(dk, c, 1'b1, 1'b1, ERR_NONE);
    sb_cur    = over_cur ? mk_item(KIND_STRING, 8'h00, 1'b0, 1'b1, ERR_LONG)
                         : mk_item(KIND_STRING, c, 1'b1, 1'b0, ERR_NONE);
    sb_new    = over_new ? mk_item(KIND_STRING, 8'h00, 1'b0, 1'b1, ERR_LONG)
                         : mk_item(KIND_STRING, c, 1'b1, 1'b0, ERR_NONE);
    drain_q   = (mode_r == MODE_SQ) ? MODE_DRAIN_SQ : MODE_DRAIN_DQ;

    step.n    = 2'd0;
    step.r0   = close_it;
    step.r1   = dlm_it;
    mode_nxt  = mode_r;
    chars_nxt = chars_r;

    if (item.end_of_input) begin
      case (mode_r)
        MODE_UNQ: begin
          step.n = 2'd1;
        end
        MODE_SQ, MODE_DQ, MODE_COMMENT, MODE_DRAIN_SQ, MODE_DRAIN_DQ: begin
          step.n  = 2'd1;
          step.r0 = unterm_it;
        end
        default: ;
      endcase
      mode_nxt  = MODE_BETWEEN;
      chars_nxt = '0;
    end else begin
      case (mode_r)
        MODE_BETWEEN: begin
          if (ws) begin
            // skip
          end else if (dlm) begin
            step.n  = 2'd1;
            step.r0 = dlm_it;
          end else if (c == CH_SQUOTE) begin
            mode_nxt  = MODE_SQ;
            chars_nxt = '0;
          end else if (c == CH_DQUOTE) begin
            mode_nxt  = MODE_DQ;
            chars_nxt = '0;
          end else if (c == CH_LBRACKET) begin
            mode_nxt = MODE_COMMENT;
          end else begin
            step.n  = 2'd1;
            step.r0 = sb_new;
            if (over_new) begin
              mode_nxt  = MODE_DRAIN_UNQ;
              chars_nxt = '0;
            end else begin
              mode_nxt  = MODE_UNQ;
              chars_nxt = LEN_W'(1);
            end
          end
        end
        MODE_UNQ: begin
          if (dlm || ws) begin
            step.n    = dlm ? 2'd2 : 2'd1;
            mode_nxt  = MODE_BETWEEN;
            chars_nxt = '0;
          end else begin
            step.n  = 2'd1;
            step.r0 = sb_cur;
            if (over_cur) begin
              mode_nxt  = MODE_DRAIN_UNQ;
              chars_nxt = '0;
            end else begin
              chars_nxt = chars_r + LEN_W'(1);
            end
          end
        end
        MODE_SQ, MODE_DQ: begin
          if (c == ((mode_r == MODE_SQ) ? CH_SQUOTE : CH_DQUOTE)) begin
            step.n    = 2'd1;
            mode_nxt  = MODE_BETWEEN;
            chars_nxt = '0;
          end else begin
            step.n  = 2'd1;
            step.r0 = sb_cur;
            if (over_cur) begin
              mode_nxt  = drain_q;
              chars_nxt = '0;
            end else begin
              chars_nxt = chars_r + LEN_W'(1);
            end
          end
        end
        MODE_COMMENT: begin
          if (c == CH_RBRACKET) mode_nxt = MODE_BETWEEN;
        end
        MODE_DRAIN_UNQ: begin
          if (dlm) begin
            step.n   = 2'd1;
            step.r0  = dlm_it;
            mode_nxt = MODE_BETWEEN;
          end else if (ws) begin
            mode_nxt = MODE_BETWEEN;
          end
        end
        MODE_DRAIN_SQ: begin
          if (c == CH_SQUOTE) mode_nxt = MODE_BETWEEN;
        end
        MODE_DRAIN_DQ: begin
          if (c == CH_DQUOTE) mode_nxt = MODE_BETWEEN;
        end
        default: begin
          mode_nxt = MODE_BETWEEN;
        end
      endcase
    end
  end

endmodule

// ===== sv/nwl_out_queue.sv =====
// ----------------------------------------------------------------------------
// nwl_out_queue
// Small result queue: takes up to two results a cycle, hands out one while pop is high.
// ----------------------------------------------------------------------------
module nwl_out_queue import nwl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  push_n,
  input  out_item_t   push_r0,
  input  out_item_t   push_r1,
  input  logic        pop,
  output logic        head_valid,
  output out_item_t   head,
  output nwl_q_stat_t stat
);

  out_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QLVL_W-1:0] level_r;
  logic [QPTR_W-1:0] wr_ptr1;
  logic              do_pop;

  assign wr_ptr1    = wr_ptr_r + QPTR_W'(1);
  assign head_valid = (level_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;
  assign stat.level = level_r;
  assign stat.room2 = (level_r <= QLVL_W'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[wr_ptr_r] <= push_r0;
    if (push_n == 2'd2) mem_r[wr_ptr1]  <= push_r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(push_n);
      if (do_pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      level_r  <= level_r + QLVL_W'(push_n) - QLVL_W'(do_pop);
    end
  end

endmodule
